// ===== rtl/core/klcd_pkg.sv =====
package klcd_pkg;

  localparam int MAX_KEYS_DEF = 7;

  localparam int KEY_W   = 8;
  localparam int PLEN_W  = 3;
  localparam int PCHR_W  = 56;
  localparam int CFG_W   = 56;
  localparam int CIDX_W  = 2;
  localparam int EV_W    = 3;
  localparam int DUTY_W  = 8;
  localparam int PASS_MAX = 7;

  typedef enum logic [CIDX_W-1:0] {
    REG_DECRYPT_KEY = 2'd0,
    REG_PASS_LENGTH = 2'd1,
    REG_PASS_CHARS  = 2'd2
  } reg_idx_t;

  typedef enum logic [EV_W-1:0] {
    EV_STORED   = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_ACCEPTED = 3'd2,
    EV_REJECTED = 3'd3,
    EV_ERASED   = 3'd4,
    EV_TOGGLED  = 3'd5,
    EV_LIGHT    = 3'd6,
    EV_TEMP     = 3'd7
  } ev_code_t;

  localparam logic [KEY_W-1:0]  KEY_RST   = 8'd129;
  localparam logic [PLEN_W-1:0] PLEN_RST  = 3'd3;
  localparam logic [PCHR_W-1:0] PCHR_RST  = 56'd3355185;

  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_PLAIN = 8'h50;

  localparam logic signed [7:0] TEMP_HOT  = 8'sd55;
  localparam logic signed [7:0] TEMP_COLD = 8'sd3;

  localparam logic [DUTY_W-1:0] DUTY_100 = DUTY_W'(100 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_90  = DUTY_W'(90 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_80  = DUTY_W'(80 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_75  = DUTY_W'(75 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_70  = DUTY_W'(70 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_60  = DUTY_W'(60 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_50  = DUTY_W'(50 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_25  = DUTY_W'(25 * 255 / 100);
  localparam logic [DUTY_W-1:0] DUTY_0   = '0;

endpackage

// ===== rtl/core/keypad_lock_climate_duty_core.sv =====
// Keypad lock with climate and lamp duty control. Each received byte is XORed with
// decrypt_key; while locked it edits a key entry of up to MAX_KEYS keys ('*' checks the
// entry against the password, '#' erases a key, a raw 'P' flips plain or masked echo),
// and once unlocked the bytes alternate light and temperature readings that set the lamp,
// heater and cooler PWM compare values and the warning LEDs and buzzers. One byte is taken
// every cycle while no stalled result blocks it; a result word is offered once its byte has
// passed the input register and then the result register around the single-pass decode
// logic, and a stalled result holds one more byte in the input register before in_stall
// rises. Configuration writes are taken at any time but are meant for an idle block.
module keypad_lock_climate_duty_core #(
  parameter int MAX_KEYS = klcd_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [klcd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [klcd_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_unlocked,
  output logic [2:0]                    out_event_res,
  output logic [7:0]                    out_echo_char,
  output logic                          out_show_plain,
  output logic [2:0]                    out_entered_count,
  output logic [7:0]                    out_cooler_duty,
  output logic [7:0]                    out_heater_duty,
  output logic [7:0]                    out_light_duty,
  output logic                          out_hot_led,
  output logic                          out_cold_led,
  output logic                          out_hot_buzzer,
  output logic                          out_cold_buzzer
);

  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int CMP_W = (CNT_W > klcd_pkg::PLEN_W) ? CNT_W : klcd_pkg::PLEN_W;

  // configuration
  logic [klcd_pkg::KEY_W-1:0]  key_r;
  logic [klcd_pkg::PLEN_W-1:0] plen_r;
  logic [klcd_pkg::PCHR_W-1:0] pchr_r;

  // handshake
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       advance;

  // block state
  logic [7:0]       entry_buf_r [MAX_KEYS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             unlocked_r, unlocked_nxt;
  logic             plain_r, plain_nxt;
  logic             temp_turn_r, temp_turn_nxt;
  logic [7:0]       cool_r, cool_nxt;
  logic [7:0]       heat_r, heat_nxt;
  logic [7:0]       lamp_r, lamp_nxt;
  logic             hot_led_r, hot_led_nxt;
  logic             cold_led_r, cold_led_nxt;
  logic             hot_buz_r, hot_buz_nxt;
  logic             cold_buz_r, cold_buz_nxt;

  klcd_pkg::ev_code_t event_r, event_nxt;
  logic [7:0]         echo_r, echo_nxt;

  logic [7:0]          dec;
  logic signed [7:0]   rd;
  logic                store;
  logic [MAX_KEYS-1:0] lane_ok;
  logic                pass_match;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  assign dec = in_byte_r ^ key_r;
  assign rd  = signed'(dec);

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_lane
    if (i < klcd_pkg::PASS_MAX) begin : g_cmp
      assign lane_ok[i] = (CNT_W'(i) >= count_r) || (entry_buf_r[i] == pchr_r[8*i +: 8]);
    end else begin : g_pass
      assign lane_ok[i] = 1'b1;
    end
  end

  assign pass_match = (CMP_W'(count_r) == CMP_W'(plen_r)) && (&lane_ok);

  always_comb begin
    count_nxt     = count_r;
    unlocked_nxt  = unlocked_r;
    plain_nxt     = plain_r;
    temp_turn_nxt = temp_turn_r;
    cool_nxt      = cool_r;
    heat_nxt      = heat_r;
    lamp_nxt      = lamp_r;
    hot_led_nxt   = hot_led_r;
    cold_led_nxt  = cold_led_r;
    hot_buz_nxt   = hot_buz_r;
    cold_buz_nxt  = cold_buz_r;
    event_nxt     = klcd_pkg::EV_DROPPED;
    echo_nxt      = 8'd0;
    store         = 1'b0;
    if (!unlocked_r) begin
      if (dec == klcd_pkg::CHR_STAR) begin
        if (pass_match) begin
          unlocked_nxt = 1'b1;
          event_nxt    = klcd_pkg::EV_ACCEPTED;
        end else begin
          count_nxt = '0;
          event_nxt = klcd_pkg::EV_REJECTED;
        end
      end else if (dec == klcd_pkg::CHR_HASH) begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
          event_nxt = klcd_pkg::EV_ERASED;
        end
      end else if (in_byte_r == klcd_pkg::CHR_PLAIN) begin
        plain_nxt = !plain_r;
        event_nxt = klcd_pkg::EV_TOGGLED;
      end else if (count_r < CNT_W'(MAX_KEYS)) begin
        store     = 1'b1;
        count_nxt = count_r + 1'b1;
        echo_nxt  = plain_r ? dec : klcd_pkg::CHR_STAR;
        event_nxt = klcd_pkg::EV_STORED;
      end
    end else begin
      temp_turn_nxt = !temp_turn_r;
      if (temp_turn_r) begin
        event_nxt = klcd_pkg::EV_TEMP;
        cool_nxt  = klcd_pkg::DUTY_0;
        heat_nxt  = klcd_pkg::DUTY_0;
        if (rd > klcd_pkg::TEMP_HOT) begin
          hot_led_nxt  = !hot_led_r;
          cold_led_nxt = 1'b0;
          hot_buz_nxt  = 1'b1;
          cold_buz_nxt = 1'b0;
        end else if (rd < klcd_pkg::TEMP_COLD) begin
          hot_led_nxt  = 1'b0;
          cold_led_nxt = !cold_led_r;
          hot_buz_nxt  = 1'b0;
          cold_buz_nxt = 1'b1;
        end else begin
          hot_led_nxt  = 1'b0;
          cold_led_nxt = 1'b0;
          hot_buz_nxt  = 1'b0;
          cold_buz_nxt = 1'b0;
          if (rd <= 8'sd5)       heat_nxt = klcd_pkg::DUTY_100;
          else if (rd <= 8'sd10) heat_nxt = klcd_pkg::DUTY_75;
          else if (rd <= 8'sd15) heat_nxt = klcd_pkg::DUTY_50;
          else if (rd <= 8'sd20) heat_nxt = klcd_pkg::DUTY_25;
          else if (rd <= 8'sd25) heat_nxt = klcd_pkg::DUTY_0;
          else if (rd <= 8'sd30) cool_nxt = klcd_pkg::DUTY_50;
          else if (rd <= 8'sd35) cool_nxt = klcd_pkg::DUTY_60;
          else if (rd <= 8'sd40) cool_nxt = klcd_pkg::DUTY_70;
          else if (rd <= 8'sd45) cool_nxt = klcd_pkg::DUTY_80;
          else if (rd <= 8'sd50) cool_nxt = klcd_pkg::DUTY_90;
          else                   cool_nxt = klcd_pkg::DUTY_100;
        end
      end else begin
        event_nxt = klcd_pkg::EV_LIGHT;
        if (rd >= 8'sd0 && rd <= 8'sd24)       lamp_nxt = klcd_pkg::DUTY_100;
        else if (rd >= 8'sd25 && rd <= 8'sd49) lamp_nxt = klcd_pkg::DUTY_75;
        else if (rd >= 8'sd50 && rd <= 8'sd74) lamp_nxt = klcd_pkg::DUTY_50;
        else if (rd >= 8'sd75 && rd <= 8'sd99) lamp_nxt = klcd_pkg::DUTY_25;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= klcd_pkg::KEY_RST;
      plen_r <= klcd_pkg::PLEN_RST;
      pchr_r <= klcd_pkg::PCHR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        klcd_pkg::REG_DECRYPT_KEY: key_r  <= cfg_wdata[klcd_pkg::KEY_W-1:0];
        klcd_pkg::REG_PASS_LENGTH: plen_r <= cfg_wdata[klcd_pkg::PLEN_W-1:0];
        klcd_pkg::REG_PASS_CHARS:  pchr_r <= cfg_wdata[klcd_pkg::PCHR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      event_r <= event_nxt;
      echo_r  <= echo_nxt;
    end
  end

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_buf
    always_ff @(posedge clk) begin
      if (advance && store && (count_r == CNT_W'(i))) begin
        entry_buf_r[i] <= dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      count_r     <= '0;
      unlocked_r  <= 1'b0;
      plain_r     <= 1'b0;
      temp_turn_r <= 1'b0;
      cool_r      <= '0;
      heat_r      <= '0;
      lamp_r      <= '0;
      hot_led_r   <= 1'b0;
      cold_led_r  <= 1'b0;
      hot_buz_r   <= 1'b0;
      cold_buz_r  <= 1'b0;
    end else begin
      in_vld_r  <= (in_valid && !in_stall) || (in_vld_r && !advance);
      out_vld_r <= advance || (out_vld_r && out_stall);
      if (advance) begin
        count_r     <= count_nxt;
        unlocked_r  <= unlocked_nxt;
        plain_r     <= plain_nxt;
        temp_turn_r <= temp_turn_nxt;
        cool_r      <= cool_nxt;
        heat_r      <= heat_nxt;
        lamp_r      <= lamp_nxt;
        hot_led_r   <= hot_led_nxt;
        cold_led_r  <= cold_led_nxt;
        hot_buz_r   <= hot_buz_nxt;
        cold_buz_r  <= cold_buz_nxt;
      end
    end
  end

  // state only moves together with a new result word, so it is shown directly
  assign out_valid         = out_vld_r;
  assign out_unlocked      = unlocked_r;
  assign out_event_res     = event_r;
  assign out_echo_char     = echo_r;
  assign out_show_plain    = plain_r;
  assign out_entered_count = 3'(count_r);
  assign out_cooler_duty   = cool_r;
  assign out_heater_duty   = heat_r;
  assign out_light_duty    = lamp_r;
  assign out_hot_led       = hot_led_r;
  assign out_cold_led      = cold_led_r;
  assign out_hot_buzzer    = hot_buz_r;
  assign out_cold_buzzer   = cold_buz_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_KEYS))
    else $error("entry count beyond buffer depth");

  a_unlock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    unlocked_r |=> unlocked_r)
    else $error("lock closed without reset");

  a_one_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
    !(hot_buz_r && cold_buz_r))
    else $error("both buzzers on");

  a_echo_only_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (event_r != klcd_pkg::EV_STORED) |-> echo_r == 8'd0)
    else $error("echo on a word that stored no key");

  a_reading_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (event_r == klcd_pkg::EV_LIGHT || event_r == klcd_pkg::EV_TEMP)
    |-> unlocked_r)
    else $error("reading word while locked");

endmodule
